[design/lr_pkg.sv]
package lr_pkg;

  localparam int COORD_W = 6;

  typedef logic [COORD_W-1:0] coord_t;

  // one classified line, as handed from the front to the back
  typedef struct packed {
    coord_t                x0;
    coord_t                y0;
    logic                  x_major;
    logic                  major_neg;   // major axis steps downwards
    coord_t                len;         // |d_major|, pixel count minus one
    logic signed [COORD_W:0] d_minor;   // signed minor delta
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic   busy;
    logic   pop;
    coord_t rem;
  } bstat_t;

endpackage

[design/lr_front.sv]
module lr_front #(
  parameter int CANVAS_SIZE = 64
) (
  input  lr_pkg::coord_t start_x,
  input  lr_pkg::coord_t start_y,
  input  lr_pkg::coord_t end_x,
  input  lr_pkg::coord_t end_y,
  output lr_pkg::cmd_t   cmd
);
  import lr_pkg::*;

  localparam coord_t MAX_C = COORD_W'(CANVAS_SIZE - 1);

  coord_t x0, y0, x1, y1;
  coord_t adx, ady;
  logic signed [COORD_W:0] dx, dy;
  logic x_major;

  // saturate to the canvas
  assign x0 = (start_x > MAX_C) ? MAX_C : start_x;
  assign y0 = (start_y > MAX_C) ? MAX_C : start_y;
  assign x1 = (end_x > MAX_C) ? MAX_C : end_x;
  assign y1 = (end_y > MAX_C) ? MAX_C : end_y;

  assign dx = $signed({1'b0, x1}) - $signed({1'b0, x0});
  assign dy = $signed({1'b0, y1}) - $signed({1'b0, y0});

  assign adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
  assign ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

  // ties go to x
  assign x_major = (adx >= ady);

  always_comb begin
    cmd.x0        = x0;
    cmd.y0        = y0;
    cmd.x_major   = x_major;
    cmd.major_neg = x_major ? dx[COORD_W] : dy[COORD_W];
    cmd.len       = x_major ? adx : ady;
    cmd.d_minor   = x_major ? dy : dx;
  end

endmodule

[design/lr_queue.sv]
module lr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lr_pkg::cmd_t  wr_cmd,
  input  logic          pop,
  output lr_pkg::cmd_t  rd_cmd,
  output lr_pkg::qstat_t stat
);
  import lr_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign rd_cmd     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

[design/lr_back.sv]
module lr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  lr_pkg::cmd_t   q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output lr_pkg::coord_t out_pixel_x,
  output lr_pkg::coord_t out_pixel_y,
  output logic           out_last_pixel,
  output lr_pkg::bstat_t stat
);
  import lr_pkg::*;

  localparam int EW = COORD_W + 3;

  logic busy_r, busy_nxt;
  logic x_major_r, major_neg_r;
  coord_t len_r, rem_r, rem_nxt;
  coord_t major_r, major_nxt, minor_r, minor_nxt;
  logic signed [COORD_W:0] d_r;
  logic signed [EW-1:0] err_r, err_nxt, e_sum, two_len;
  logic adv, finish;
  logic ov_r, ov_nxt;
  coord_t ox_r, oy_r;
  logic ol_r;

  assign adv    = busy_r && (!ov_r || !out_stall);
  assign finish = adv && (rem_r == '0);
  assign q_pop  = q_valid && (!busy_r || finish);

  assign two_len = $signed({2'b00, len_r, 1'b0});
  assign e_sum   = err_r + $signed({d_r[COORD_W], d_r, 1'b0});

  // one correction at most per step, since |d_minor| <= len
  always_comb begin
    major_nxt = major_neg_r ? major_r - 1'b1 : major_r + 1'b1;
    minor_nxt = minor_r;
    err_nxt   = e_sum;
    if (e_sum >= two_len) begin
      err_nxt   = e_sum - two_len;
      minor_nxt = minor_r + 1'b1;
    end else if (e_sum < 0) begin
      err_nxt   = e_sum + two_len;
      minor_nxt = minor_r - 1'b1;
    end
    rem_nxt  = rem_r - 1'b1;
    busy_nxt = busy_r && !finish;
    ov_nxt   = adv ? 1'b1 : (ov_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= q_pop ? 1'b1 : busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_major_r   <= q_cmd.x_major;
      major_neg_r <= q_cmd.major_neg;
      len_r       <= q_cmd.len;
      rem_r       <= q_cmd.len;
      d_r         <= q_cmd.d_minor;
      major_r     <= q_cmd.x_major ? q_cmd.x0 : q_cmd.y0;
      minor_r     <= q_cmd.x_major ? q_cmd.y0 : q_cmd.x0;
      err_r       <= $signed({3'b000, q_cmd.len});
    end else if (adv) begin
      rem_r   <= rem_nxt;
      major_r <= major_nxt;
      minor_r <= minor_nxt;
      err_r   <= err_nxt;
    end
    if (adv) begin
      ox_r <= x_major_r ? major_r : minor_r;
      oy_r <= x_major_r ? minor_r : major_r;
      ol_r <= (rem_r == '0);
    end
  end

  assign out_valid      = ov_r;
  assign out_pixel_x    = ox_r;
  assign out_pixel_y    = oy_r;
  assign out_last_pixel = ol_r;

  assign stat.busy = busy_r;
  assign stat.pop  = q_pop;
  assign stat.rem  = rem_r;

endmodule

[design/line_rasterizer.sv]
// DDA line rasterizer. Each input transfer carries two endpoints; the block
// emits every pixel of the line from the first to the second, both included,
// max(|dx|,|dy|)+1 pixels, with last_pixel set on the second endpoint.
// Coordinates above CANVAS_SIZE-1 are saturated first. The larger delta picks
// the major axis (x on a tie), which steps by one per pixel; the minor axis
// follows start + k*d/len rounded half up, tracked exactly with an integer
// error term. Rate: one pixel per cycle when the output is not stalled, and
// queued lines follow each other with no gap. The stepper in the back end
// sets that figure. A two-entry command queue sits between the classifier
// and the stepper, so up to two further lines are taken while one is being
// drawn. When the block is empty, a new line passes a queue slot, the stepper
// registers and the output register. No clearing pass after reset.
module line_rasterizer #(
  parameter int CANVAS_SIZE = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  lr_pkg::coord_t in_start_x,
  input  lr_pkg::coord_t in_start_y,
  input  lr_pkg::coord_t in_end_x,
  input  lr_pkg::coord_t in_end_y,
  output logic           out_valid,
  input  logic           out_stall,
  output lr_pkg::coord_t out_pixel_x,
  output lr_pkg::coord_t out_pixel_y,
  output logic           out_last_pixel
);
  import lr_pkg::*;

  cmd_t   f_cmd;   // classified line from the front
  cmd_t   q_cmd;   // head of the queue
  qstat_t q_stat;
  bstat_t b_stat;
  logic   push;
  logic   pop;

  // the queue only refuses when both slots hold lines
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  lr_front #(
    .CANVAS_SIZE(CANVAS_SIZE)
  ) u_front (
    .start_x(in_start_x),
    .start_y(in_start_y),
    .end_x  (in_end_x),
    .end_y  (in_end_y),
    .cmd    (f_cmd)
  );

  lr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wr_cmd(f_cmd),
    .pop   (pop),
    .rd_cmd(q_cmd),
    .stat  (q_stat)
  );

  lr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (!q_stat.empty),
    .q_cmd         (q_cmd),
    .q_pop         (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_last_pixel(out_last_pixel),
    .stat          (b_stat)
  );

  // queue occupancy is consistent
  a_q_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  // stepper only takes a line that is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    b_stat.pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // remaining count never exceeds the canvas
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    b_stat.busy |-> (32'(b_stat.rem) <= CANVAS_SIZE - 1))
    else $error("pixel count beyond canvas");

  // a fresh line popped makes the stepper busy next cycle
  a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    b_stat.pop |=> b_stat.busy)
    else $error("stepper idle after taking a line");

endmodule

[tb/line_rasterizer_checker.sv]
module line_rasterizer_checker #(
  parameter int CANVAS_SIZE = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  lr_pkg::coord_t in_start_x,
  input  lr_pkg::coord_t in_start_y,
  input  lr_pkg::coord_t in_end_x,
  input  lr_pkg::coord_t in_end_y,
  input  logic           out_valid,
  input  logic           out_stall,
  input  lr_pkg::coord_t out_pixel_x,
  input  lr_pkg::coord_t out_pixel_y,
  input  logic           out_last_pixel,
  output int             fail_count,
  output int             pixels_due,
  output int             pixels_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import lr_pkg::*;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  pixel_t pixel_q[$];
  pixel_t want;

  initial begin
    fail_count     = 0;
    pixels_due     = 0;
    pixels_checked = 0;
  end

  function automatic int saturate_coord(coord_t c);
    return (int'(c) > CANVAS_SIZE - 1) ? CANVAS_SIZE - 1 : int'(c);
  endfunction

  // floor(base + k*delta/len + 1/2), kept in integers
  function automatic int round_half_up(int base, int k, int delta, int len);
    int num;
    num = 2 * base * len + 2 * k * delta + len;
    if (num < 0) num = 0;
    return num / (2 * len);
  endfunction

  task automatic queue_line_pixels(coord_t sx_in, coord_t sy_in, coord_t ex_in, coord_t ey_in);
    int     x0, y0, x1, y1, dx, dy, sx, sy, adx, ady, len, px, py;
    bit     x_major;
    pixel_t p;
    x0 = saturate_coord(sx_in);
    y0 = saturate_coord(sy_in);
    x1 = saturate_coord(ex_in);
    y1 = saturate_coord(ey_in);
    dx = x1 - x0;
    dy = y1 - y0;
    sx = (dx < 0) ? -1 : 1;
    sy = (dy < 0) ? -1 : 1;
    adx = dx * sx;
    ady = dy * sy;
    x_major = (adx >= ady);
    len = x_major ? adx : ady;
    for (int k = 0; k <= len; k++) begin
      if (len == 0) begin
        px = x0;
        py = y0;
      end else if (x_major) begin
        px = x0 + sx * k;
        py = round_half_up(y0, k, dy, adx);
      end else begin
        py = y0 + sy * k;
        px = round_half_up(x0, k, dx, ady);
      end
      p.x    = coord_t'(px);
      p.y    = coord_t'(py);
      p.last = (k == len);
      pixel_q.push_back(p);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pixel_q.delete();
    end else begin
      // compare before queueing: a new line cannot produce a pixel at its own edge
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected pixel x=%0d y=%0d last=%b", $realtime,
                     out_pixel_x, out_pixel_y, out_last_pixel);
          fail_count++;
        end else begin
          want = pixel_q.pop_front();
          if (out_pixel_x !== want.x || out_pixel_y !== want.y ||
              out_last_pixel !== want.last) begin
            if (fail_count < 10)
              $display("%0t: pixel %0d expected x=%0d y=%0d last=%b, got x=%0d y=%0d last=%b",
                       $realtime, pixels_checked, want.x, want.y, want.last,
                       out_pixel_x, out_pixel_y, out_last_pixel);
            fail_count++;
          end
        end
        pixels_checked++;
      end
      if (in_valid && !in_stall)
        queue_line_pixels(in_start_x, in_start_y, in_end_x, in_end_y);
    end
    pixels_due <= pixel_q.size();
  end

endmodule

[tb/tb_line_rasterizer.sv]
module tb_line_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;

  import lr_pkg::*;

  localparam int CANVAS_SIZE = 64;
  localparam int N_RANDOM    = 412;
  localparam int MAX_GAP     = 60;
  // tail after the last expected pixel: a full-length line plus slack
  localparam int TAIL_CYCLES = 2 * CANVAS_SIZE + 16;
  // worst case: every line a full 64 pixels, each pixel waiting out the longest
  // stall, each line behind the longest sender gap; then taken four times over
  localparam int CYCLE_LIMIT =
    4 * (450 * (CANVAS_SIZE * (MAX_GAP + 9) + MAX_GAP + 4) + 1000);

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  coord_t in_start_x = '0;
  coord_t in_start_y = '0;
  coord_t in_end_x = '0;
  coord_t in_end_y = '0;
  logic   out_stall = 1'b0;
  logic   in_stall;
  logic   out_valid;
  coord_t out_pixel_x;
  coord_t out_pixel_y;
  logic   out_last_pixel;

  int fail_count;
  int pixels_due;
  int pixels_checked;

  // calm: neither side idles while set
  bit calm = 1'b0;
  int cycle_count = 0;
  int n_points = 0, n_axis = 0, n_diag = 0, n_sloped = 0;

  always #5 clk = ~clk;

  line_rasterizer #(.CANVAS_SIZE(CANVAS_SIZE)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_last_pixel(out_last_pixel)
  );

  line_rasterizer_checker #(.CANVAS_SIZE(CANVAS_SIZE)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_last_pixel(out_last_pixel),
    .fail_count    (fail_count),
    .pixels_due    (pixels_due),
    .pixels_checked(pixels_checked)
  );

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, MAX_GAP);
  endfunction

  // A coordinate within a few pixels of c, kept on the canvas.
  function automatic int near(int c);
    int v;
    v = c + int'($urandom_range(0, 12)) - 6;
    if (v < 0) v = 0;
    if (v > CANVAS_SIZE - 1) v = CANVAS_SIZE - 1;
    return v;
  endfunction

  // Receiver back-pressure: a run of free cycles, then a stall of random length.
  // Each clock edge gets exactly one assignment to out_stall.
  int run_left = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0 && !calm) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (run_left > 0) begin
        run_left--;
      end else begin
        run_left   = $urandom_range(1, 8);
        stall_left = calm ? 0 : rand_gap();
      end
    end
  end

  // Run limit; a hang in either channel ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d pixels outstanding",
               cycle_count, pixels_due);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // One line transfer. Valid goes high at a clock edge and stays up until the
  // transfer; with no gap afterwards it simply stays high for the next line.
  task automatic send_line(int x0, int y0, int x1, int y1);
    int gap;
    int adx, ady;
    in_valid   <= 1'b1;
    in_start_x <= coord_t'(x0);
    in_start_y <= coord_t'(y0);
    in_end_x   <= coord_t'(x1);
    in_end_y   <= coord_t'(y1);
    do @(posedge clk); while (in_stall);
    adx = (x1 > x0) ? x1 - x0 : x0 - x1;
    ady = (y1 > y0) ? y1 - y0 : y0 - y1;
    if (adx == 0 && ady == 0) n_points++;
    else if (adx == 0 || ady == 0) n_axis++;
    else if (adx == ady) n_diag++;
    else n_sloped++;
    gap = calm ? 0 : rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender off until every predicted pixel has been transferred.
  // pixels_due is registered, so look from the next edge onwards.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pixels_due != 0);
  endtask

  initial begin
    int kind, x0, y0, x1, y1, d;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines: points, full-length axis lines both ways, the 45-degree
    // ties, exact halves on either axis and in both directions, canvas corners.
    send_line(0, 0, 0, 0);
    send_line(63, 63, 63, 63);
    send_line(0, 0, 63, 0);
    send_line(63, 5, 0, 5);
    send_line(7, 0, 7, 63);
    send_line(7, 63, 7, 0);
    send_line(0, 0, 63, 63);
    send_line(63, 0, 0, 63);
    send_line(0, 63, 63, 0);
    send_line(63, 63, 0, 0);
    send_line(0, 0, 2, 1);      // half rounds up on the minor y
    send_line(10, 10, 6, 11);   // same, major x stepping down
    send_line(0, 0, 1, 2);      // half on the minor x
    send_line(0, 10, 2, 9);     // falling minor, half goes to the larger value
    send_line(63, 0, 0, 1);
    send_line(0, 0, 1, 63);
    send_line(32, 32, 33, 33);
    send_line(1, 0, 0, 63);
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      // a stretch with no idling on either side
      calm = (i >= 150 && i < 190);
      if (i % 100 == 99) drain();
      kind = $urandom_range(0, 99);
      x0 = $urandom_range(0, 63);
      y0 = $urandom_range(0, 63);
      if (kind < 40) begin
        // short lines keep the run quick
        x1 = near(x0);
        y1 = near(y0);
      end else if (kind < 80) begin
        x1 = $urandom_range(0, 63);
        y1 = $urandom_range(0, 63);
      end else if (kind < 90) begin
        x1 = $urandom_range(0, 1) ? x0 : $urandom_range(0, 63);
        y1 = (x1 == x0) ? $urandom_range(0, 63) : y0;
      end else if (kind < 95) begin
        x1 = $urandom_range(0, 63);
        d  = (x1 > x0) ? x1 - x0 : x0 - x1;
        y0 = $urandom_range(0, 63 - d);
        y1 = y0 + d;
        if ($urandom_range(0, 1)) begin
          d  = y0;
          y0 = y1;
          y1 = d;
        end
      end else begin
        x0 = $urandom_range(0, 1) ? 63 : 0;
        y0 = $urandom_range(0, 1) ? 63 : 0;
        x1 = $urandom_range(0, 1) ? 63 : 0;
        y1 = $urandom_range(0, 1) ? 63 : 0;
      end
      send_line(x0, y0, x1, y1);
    end
    calm = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Drew %0d lines: %0d single points, %0d axis-aligned, %0d at 45 degrees, %0d sloped",
             n_points + n_axis + n_diag + n_sloped, n_points, n_axis, n_diag, n_sloped);
    $display("%0d pixel transfers checked under random sender gaps and receiver stalls",
             pixels_checked);
    if (fail_count == 0 && pixels_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d failures, %0d pixels never arrived", fail_count, pixels_due);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
